// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the window vote input filter
// Shared concurrent checks, clocked on aclk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define WVF_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("%m: implication check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define WVF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("%m: next-cycle check failed");

`endif

// ===== design/wvf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wvf_pkg
// Constants, register codes and shared types of the window vote filter.
// ---------------------------------------------------------------------------
package wvf_pkg;

    // Window and line counts
    localparam int WINDOW   = 5;
    localparam int CHANNELS = 16;
    localparam int DATA_W   = 16;
    localparam int LANES    = (CHANNELS < DATA_W) ? CHANNELS : DATA_W;
    localparam int HIST_D   = WINDOW - 1;

    // Counter and compare widths
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int CFG_W = 3;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUORUM       = 1'd1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] CHANGE_LIMIT_RST = 3'd2;
    localparam logic [CFG_W-1:0] QUORUM_RST       = 3'd3;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic [CFG_W-1:0] change_limit;
        logic [CFG_W-1:0] quorum;
    } cfg_t;

    typedef struct packed {
        logic level;
        logic undecided;
    } lane_res_t;

    typedef struct packed {
        word_t filtered_word;
        word_t undecided_mask;
    } result_t;

endpackage
`default_nettype wire

// ===== design/wvf_lane.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wvf_lane
// Vote logic of one input line over the sample window.
// ---------------------------------------------------------------------------
module wvf_lane (
    input  wvf_pkg::cfg_t                 cfg,
    input  logic [wvf_pkg::WINDOW-1:0]    win,   // bit 0 newest, top bit oldest
    input  logic                          held,
    output wvf_pkg::lane_res_t            res
);
    import wvf_pkg::*;

    logic [CNT_W-1:0] ones;
    logic [CNT_W-1:0] zeros;
    logic [CNT_W-1:0] changes;
    logic             noisy;

    // Count ones and level changes between neighboring samples
    always_comb begin
        ones    = '0;
        changes = '0;
        for (int k = 0; k < WINDOW; k++) begin
            ones = ones + CNT_W'(win[k]);
        end
        for (int k = 0; k < WINDOW - 1; k++) begin
            changes = changes + CNT_W'(win[k] ^ win[k+1]);
        end
    end

    assign zeros = CNT_W'(WINDOW) - ones;
    assign noisy = CMP_W'(changes) > CMP_W'(cfg.change_limit);

    // Decide: strict threshold on noisy lines, majority otherwise
    always_comb begin
        res.undecided = 1'b0;
        if (noisy) begin
            if (CMP_W'(zeros) >= CMP_W'(cfg.quorum)) begin
                res.level = 1'b0;
            end else if (CMP_W'(ones) >= CMP_W'(cfg.quorum)) begin
                res.level = 1'b1;
            end else begin
                res.level     = held;
                res.undecided = 1'b1;
            end
        end else begin
            res.level = (ones >= zeros);
        end
    end

endmodule
`default_nettype wire

// ===== design/wvf_merge.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wvf_merge
// Packs the lane decisions into result words and holds the last output.
// ---------------------------------------------------------------------------
module wvf_merge (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  wvf_pkg::lane_res_t [wvf_pkg::DATA_W-1:0] lane_res,
    input  logic                                    load,
    output wvf_pkg::word_t                          held_word,
    output wvf_pkg::result_t                        result
);
    import wvf_pkg::*;

    word_t held_reg;
    word_t held_next;

    // Gather lane results into words
    always_comb begin
        for (int i = 0; i < DATA_W; i++) begin
            result.filtered_word[i]  = lane_res[i].level;
            result.undecided_mask[i] = lane_res[i].undecided;
        end
    end

    // Advance the held word on each accepted transaction
    assign held_next = load ? result.filtered_word : held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

    assign held_word = held_reg;

endmodule
`default_nettype wire

// ===== design/wvf_out_buf.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// wvf_out_buf
// Two-entry output buffer: output register plus skid register.
// ---------------------------------------------------------------------------
module wvf_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  wvf_pkg::result_t   din,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output wvf_pkg::result_t   dout
);
    import wvf_pkg::*;

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    head_reg;
    result_t    head_next;
    result_t    skid_reg;
    result_t    skid_next;
    logic       pop;

    assign pop = m_valid && m_ready;

    // Fill, drain and refill from the skid entry
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        skid_next = skid_reg;
        case (cnt_reg)
            CNT_EMPTY: begin
                if (push) begin
                    head_next = din;
                    cnt_next  = CNT_ONE;
                end
            end
            CNT_ONE: begin
                if (push && pop) begin
                    head_next = din;
                end else if (push) begin
                    skid_next = din;
                    cnt_next  = CNT_FULL;
                end else if (pop) begin
                    cnt_next = CNT_EMPTY;
                end
            end
            CNT_FULL: begin
                if (pop) begin
                    head_next = skid_reg;
                    cnt_next  = CNT_ONE;
                end
            end
            default: begin
                cnt_next = CNT_EMPTY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CNT_EMPTY;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload holds need no reset
    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign in_ready = (cnt_reg != CNT_FULL);
    assign m_valid  = (cnt_reg != CNT_EMPTY);
    assign dout     = head_reg;

endmodule
`default_nettype wire

// ===== design/window_vote_input_filter_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// window_vote_input_filter_top
// Sixteen-line debounce filter voting over a five-sample window.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries one raw sample per transaction.
//   Result channel m_valid/m_ready carries the filtered word and the mask
//   of noisy lines that held their previous level.
//   cfg_we/cfg_index/cfg_wdata write change_limit (index 0) and the quorum
//   (index 1); write them only while no transaction is in flight.
//   Each result is registered in the output buffer before it appears on m_*.
//   Throughput: one sample per cycle while s_ready is high; all sixteen lane
//   voters evaluate the new sample and the four stored ones in the same cycle.
//   A two-entry output buffer keeps s_ready high while one result waits;
//   s_ready drops while two results are pending and rises again the cycle
//   after the receiver takes one.
//   Reset clears the sample history and held word to zero, empties the
//   buffer and restores change_limit to 2 and the quorum to 3.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module window_vote_input_filter_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [wvf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wvf_pkg::CFG_W-1:0]        cfg_wdata,
    // Input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [wvf_pkg::DATA_W-1:0]       s_raw_sample,
    // Result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [wvf_pkg::DATA_W-1:0]       m_filtered_word,
    output logic [wvf_pkg::DATA_W-1:0]       m_undecided_mask
);
    import wvf_pkg::*;

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    word_t                   hist_reg  [HIST_D];
    word_t                   hist_next [HIST_D];
    logic                    accept;
    lane_res_t [DATA_W-1:0]  lane_res;
    word_t                   held_word;
    result_t                 result;
    result_t                 out_res;
    logic                    held_match;

    assign accept = s_valid && s_ready;

    // Configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_CHANGE_LIMIT: cfg_next.change_limit = cfg_wdata;
                REG_QUORUM:       cfg_next.quorum       = cfg_wdata;
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.change_limit <= CHANGE_LIMIT_RST;
            cfg_reg.quorum       <= QUORUM_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Shift the sample history on each accepted transaction
    always_comb begin
        for (int j = 0; j < HIST_D; j++) begin
            hist_next[j] = hist_reg[j];
        end
        if (accept) begin
            hist_next[0] = s_raw_sample;
            for (int j = 1; j < HIST_D; j++) begin
                hist_next[j] = hist_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < HIST_D; j++) begin
                hist_reg[j] <= '0;
            end
        end else begin
            for (int j = 0; j < HIST_D; j++) begin
                hist_reg[j] <= hist_next[j];
            end
        end
    end

    // One voter per line; lines beyond the channel count read as zero
    for (genvar i = 0; i < DATA_W; i++) begin : g_lane
        if (i < LANES) begin : g_active
            logic [WINDOW-1:0] win;

            always_comb begin
                win[0] = s_raw_sample[i];
                for (int j = 1; j < WINDOW; j++) begin
                    win[j] = hist_reg[j-1][i];
                end
            end

            wvf_lane u_lane (
                .cfg  (cfg_reg),
                .win  (win),
                .held (held_word[i]),
                .res  (lane_res[i])
            );
        end else begin : g_idle
            assign lane_res[i] = '0;
        end
    end

    // Merge lane decisions and keep the last filtered word
    wvf_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lane_res  (lane_res),
        .load      (accept),
        .held_word (held_word),
        .result    (result)
    );

    // Output register with skid entry
    wvf_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .din      (result),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .dout     (out_res)
    );

    assign m_filtered_word  = out_res.filtered_word;
    assign m_undecided_mask = out_res.undecided_mask;

    // Undecided lines repeat the held level
    assign held_match = ((result.filtered_word & result.undecided_mask)
                         == (held_word & result.undecided_mask));

    // Checks
    `WVF_ASSERT_IMPLY(a_undecided_holds, accept, held_match)
    `WVF_ASSERT_IMPLY(a_stall_only_when_pending, !s_ready, m_valid)
    `WVF_ASSERT_NEXT(a_accept_gives_result, accept, m_valid)

endmodule
`default_nettype wire
